// File: src/htks_pkg.sv
// Shared types and constants for the heap top-k selector.
// Record, item and result structs, config index codes and the
// controller/datapath command and status bundles. No dependencies.
package htks_pkg;

	localparam int KEY_W      = 32;
	localparam int TAG_W      = 10;
	localparam int SEL_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE   = 2'd1;

	typedef struct packed {
		logic [KEY_W-1:0] dist_key;
		logic [TAG_W-1:0] item_tag;
		logic             last_item;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic [TAG_W-1:0] out_tag;
		logic             out_last;
	} out_item_t;

	// one heap entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// heap store read address source
	typedef enum logic [2:0] {
		RD_BI   = 3'd0,
		RD_LC   = 3'd1,
		RD_RC   = 3'd2,
		RD_ROOT = 3'd3,
		RD_LAST = 3'd4
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    build_init;
		logic    bi_dec;
		logic    pos_bi;
		logic    cur_cap;
		logic    left_cap;
		logic    right_cap;
		logic    move;
		logic    emit;
		logic    pop;
		logic    finish;
		logic    wr_en;
		logic    wr_child;
		logic    rd_en;
		rd_sel_t rd_sel;
	} htks_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic lc_in;
		logic rc_in;
		logic win;
		logic bi_zero;
		logic k_done;
	} htks_sts_t;

endpackage

// File: src/htks_ctrl.sv
// Sequencer for load, heap build, sift-down and extraction.
// Depends on htks_pkg for the command and status bundles.
module htks_ctrl import htks_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      last_item,
	input  htks_sts_t sts,
	output htks_cmd_t cmd,
	output logic      busy
);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_B_START = 11'b000_0000_0010,
		ST_B_NODE  = 11'b000_0000_0100,
		ST_B_CAP   = 11'b000_0000_1000,
		ST_S_A     = 11'b000_0001_0000,
		ST_S_B     = 11'b000_0010_0000,
		ST_S_C     = 11'b000_0100_0000,
		ST_S_MV    = 11'b000_1000_0000,
		ST_E_RD    = 11'b001_0000_0000,
		ST_E_OUT   = 11'b010_0000_0000,
		ST_E_CAP   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   build_q;   // high while building, low for extraction sift-downs

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_B_START) begin
				build_q <= 1'b1;
			end else if (state_q == ST_E_CAP) begin
				build_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_BI;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_item) begin
						state_d = ST_B_START;
					end
				end
			end
			ST_B_START: begin
				cmd.build_init = 1'b1;
				state_d        = ST_B_NODE;
			end
			ST_B_NODE: begin
				cmd.pos_bi = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_BI;
				state_d    = ST_B_CAP;
			end
			ST_B_CAP: begin
				cmd.cur_cap = 1'b1;
				state_d     = ST_S_A;
			end
			ST_S_A: begin
				if (sts.lc_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LC;
					state_d    = ST_S_B;
				end else begin
					// leaf reached: park the carried record
					cmd.wr_en = 1'b1;
					if (build_q && !sts.bi_zero) begin
						cmd.bi_dec = 1'b1;
						state_d    = ST_B_NODE;
					end else begin
						state_d = ST_E_RD;
					end
				end
			end
			ST_S_B: begin
				cmd.left_cap = 1'b1;
				if (sts.rc_in) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RC;
					state_d    = ST_S_C;
				end else begin
					state_d = ST_S_MV;
				end
			end
			ST_S_C: begin
				cmd.right_cap = 1'b1;
				state_d       = ST_S_MV;
			end
			ST_S_MV: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_child = sts.win;
				if (sts.win) begin
					cmd.move = 1'b1;
					state_d  = ST_S_A;
				end else if (build_q && !sts.bi_zero) begin
					cmd.bi_dec = 1'b1;
					state_d    = ST_B_NODE;
				end else begin
					state_d = ST_E_RD;
				end
			end
			ST_E_RD: begin
				if (sts.k_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_ROOT;
					state_d    = ST_E_OUT;
				end
			end
			ST_E_OUT: begin
				cmd.emit   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_LAST;
				state_d    = ST_E_CAP;
			end
			ST_E_CAP: begin
				cmd.cur_cap = 1'b1;
				cmd.pop     = 1'b1;
				state_d     = ST_S_A;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: src/htks_dpath.sv
// Datapath: heap store, counters, sift registers, config registers
// and the result register. Depends on htks_pkg.
module htks_dpath import htks_pkg::*; #(
	parameter int CAPACITY   = 1024,
	parameter int MAX_SELECT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htks_cmd_t             cmd,
	output htks_sts_t             sts,
	input  in_item_t              item,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output out_item_t             result
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = IW + 2;
	localparam int KW = $clog2(MAX_SELECT + 1);
	localparam int MW = (CW > SEL_W) ? CW : SEL_W;

	// heap store
	rec_t mem [CAPACITY];
	rec_t rd_q;

	logic [SEL_W-1:0] select_q;
	logic             mode_q;
	logic [CW-1:0]    load_count_q;
	logic [CW-1:0]    heap_size_q;
	logic [KW-1:0]    emitted_q;
	logic [KW-1:0]    k_q;
	logic [IW-1:0]    bi_q;
	logic [IW-1:0]    pos_q;
	logic [IW-1:0]    best_q;
	logic             win_q;
	rec_t             cur_q;
	rec_t             child_q;
	out_item_t        out_q;
	logic             strobe_q;

	logic [LW-1:0]    lc, rc;
	logic [IW-1:0]    rd_addr, wr_addr;
	rec_t             wr_data;
	logic             wr_go;
	logic             room;
	logic [SEL_W-1:0] sel_clamp;
	logic [MW-1:0]    k_calc;
	logic [KEY_W-1:0] ref_key;

	// order test for the current mode
	function automatic logic beats(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
			input logic mode);
		beats = mode ? (a > b) : (a < b);
	endfunction

	assign lc   = {1'b0, pos_q, 1'b1};
	assign rc   = lc + LW'(1);
	assign room = (load_count_q < CW'(CAPACITY));

	// k = min(select, MAX_SELECT, records loaded)
	assign sel_clamp = (select_q > SEL_W'(MAX_SELECT)) ? SEL_W'(MAX_SELECT) : select_q;
	assign k_calc = (MW'(sel_clamp) > MW'(load_count_q)) ? MW'(load_count_q)
		: MW'(sel_clamp);

	// read address decode
	always_comb begin
		unique case (cmd.rd_sel)
			RD_BI:   rd_addr = bi_q;
			RD_LC:   rd_addr = lc[IW-1:0];
			RD_RC:   rd_addr = rc[IW-1:0];
			RD_ROOT: rd_addr = '0;
			RD_LAST: rd_addr = IW'(heap_size_q - CW'(1));
			default: rd_addr = '0;
		endcase
	end

	// write port: incoming record, or carried / promoted record
	always_comb begin
		if (cmd.load) begin
			wr_addr = load_count_q[IW-1:0];
			wr_data = '{key: item.dist_key, tag: item.item_tag};
		end else begin
			wr_addr = pos_q;
			wr_data = cmd.wr_child ? child_q : cur_q;
		end
		wr_go = (cmd.load && room) || cmd.wr_en;
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// config and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= SEL_W'(1);
			mode_q       <= 1'b0;
			load_count_q <= '0;
			heap_size_q  <= '0;
			emitted_q    <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cfg_wr) begin
				case (cfg_index)
					CFG_SELECT_COUNT: select_q <= cfg_data[SEL_W-1:0];
					CFG_ORDER_MODE:   mode_q   <= cfg_data[0];
					default:          ;
				endcase
			end
			if (cmd.load && room) begin
				load_count_q <= load_count_q + CW'(1);
			end
			if (cmd.build_init) begin
				heap_size_q <= load_count_q;
				emitted_q   <= '0;
			end
			if (cmd.pop) begin
				heap_size_q <= heap_size_q - CW'(1);
			end
			if (cmd.emit) begin
				emitted_q <= emitted_q + KW'(1);
			end
			if (cmd.finish) begin
				load_count_q <= '0;
				heap_size_q  <= '0;
			end
		end
	end

	// sift-down working registers
	assign ref_key = win_q ? child_q.key : cur_q.key;

	always_ff @(posedge clk) begin
		if (cmd.build_init) begin
			bi_q <= IW'(load_count_q >> 1);
			k_q  <= KW'(k_calc);
		end
		if (cmd.bi_dec) begin
			bi_q <= bi_q - IW'(1);
		end
		if (cmd.pos_bi) begin
			pos_q <= bi_q;
		end
		if (cmd.pop) begin
			pos_q <= '0;
		end
		if (cmd.cur_cap) begin
			cur_q <= rd_q;
		end
		if (cmd.left_cap) begin
			child_q <= rd_q;
			best_q  <= lc[IW-1:0];
			win_q   <= beats(rd_q.key, cur_q.key, mode_q);
		end
		if (cmd.right_cap && beats(rd_q.key, ref_key, mode_q)) begin
			child_q <= rd_q;
			best_q  <= rc[IW-1:0];
			win_q   <= 1'b1;
		end
		if (cmd.move) begin
			pos_q <= best_q;
		end
		if (cmd.emit) begin
			out_q.out_key  <= rd_q.key;
			out_q.out_tag  <= rd_q.tag;
			out_q.out_last <= ((emitted_q + KW'(1)) == k_q);
		end
	end

	// status to controller
	assign sts.lc_in   = (lc < LW'(heap_size_q));
	assign sts.rc_in   = (rc < LW'(heap_size_q));
	assign sts.win     = win_q;
	assign sts.bi_zero = (bi_q == '0);
	assign sts.k_done  = (emitted_q == k_q);

	assign result_valid = strobe_q;
	assign result       = out_q;

	// checks
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q <= CW'(CAPACITY))
		else $error("load count beyond capacity");
	a_emit_k: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (emitted_q < k_q))
		else $error("emit past k");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && out_q.out_last) |-> (emitted_q == k_q))
		else $error("last flag not on final result");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (heap_size_q != '0))
		else $error("pop from empty heap");

endmodule

// File: src/heap_top_k_select.sv
// Top level of the heap top-k selector: controller plus datapath.
// Depends on htks_pkg, htks_ctrl and htks_dpath.
//
// Records are loaded one per cycle while busy is low (start high). The
// record flagged last_item raises busy: the store is turned into a min-heap
// (order_mode 0) or max-heap (order_mode 1) and the root is removed k times,
// k = min(select_count, MAX_SELECT, records loaded). Each result appears on
// result for exactly one cycle with result_valid high and cannot be held off;
// the final one carries out_last. The heap store has a single read and a
// single write port, so each sift level runs as separate steps (left read,
// right read, compare, move). Records beyond CAPACITY are dropped. No
// clearing pass follows reset. Configuration is taken while busy is low.
module heap_top_k_select import htks_pkg::*; #(
	parameter int CAPACITY   = 1024,
	parameter int MAX_SELECT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output out_item_t             result
);

	htks_cmd_t cmd;
	htks_sts_t sts;
	logic      busy_w;

	assign busy      = busy_w;
	assign cfg_ready = ~busy_w;

	htks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_item (item.last_item),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy_w)
	);

	htks_dpath #(
		.CAPACITY   (CAPACITY),
		.MAX_SELECT (MAX_SELECT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_wr       (cfg_valid & ~busy_w),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
